// ----- design/fssu_pkg.sv -----
`default_nettype none

package fssu_pkg;

  localparam int LetterSlots = 4;
  localparam int AddrW       = 4;
  localparam int MidDepth    = 4;
  localparam int OutDepth    = 4;

  localparam logic [LetterSlots-1:0][7:0] LetterReset = {8'd84, 8'd71, 8'd67, 8'd65};

  localparam logic [7:0] CharNewline = 8'd10;
  localparam logic [7:0] CharHeader  = 8'd62;
  localparam logic [7:0] CharSpace   = 8'd32;

  localparam logic [1:0] LineNone   = 2'd0;
  localparam logic [1:0] LineHeader = 2'd1;
  localparam logic [1:0] LineSeq    = 2'd2;

  localparam logic [2:0] KindRecClosed = 3'd0;
  localparam logic [2:0] KindEmpty     = 3'd1;
  localparam logic [2:0] KindUndefBase = 3'd2;
  localparam logic [2:0] KindBaseCount = 3'd3;
  localparam logic [2:0] KindSummary   = 3'd4;
  localparam logic [2:0] KindSpaceErr  = 3'd5;
  localparam logic [2:0] KindFormatErr = 3'd6;

  typedef enum logic [2:0] {
    ActBase   = 3'd0,
    ActClose  = 3'd1,
    ActSpace  = 3'd2,
    ActFormat = 3'd3,
    ActEof    = 3'd4
  } act_e;

  // word between front and back
  typedef struct packed {
    act_e       act;
    logic [2:0] code;   // matched base code, 0 if none
    logic       close;  // end of file must close the open record
  } act_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] seq_length;
    logic [31:0] seq_count;
    logic [31:0] min_length;
    logic [31:0] max_length;
    logic [2:0]  base_code;
    logic [31:0] base_count;
    logic        failed;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// ----- design/fssu_fifo.sv -----
`default_nettype none

module fssu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/fssu_front.sv -----
`default_nettype none

module fssu_front #(
  parameter int NUM_BASES = 4
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        accept_i,
  input  wire logic                                        req_type_i,
  input  wire logic [7:0]                                  char_in_i,
  input  wire logic [fssu_pkg::LetterSlots-1:0][7:0]       letters_i,
  output logic                                             qpush_o,
  output fssu_pkg::act_t                                   qword_o
);

  logic       at_line_start_q, at_line_start_d;
  logic [1:0] line_kind_q, line_kind_d;
  logic       have_header_q, have_header_d;
  logic       error_q, error_d;
  logic [1:0] kind_eff;
  logic       cont;
  logic [2:0] match;

  always_comb begin
    match = '0;
    for (int k = NUM_BASES - 1; k >= 0; k--) begin
      if (letters_i[k] == char_in_i) begin
        match = 3'(k + 1);
      end
    end
  end

  always_comb begin
    at_line_start_d = at_line_start_q;
    line_kind_d     = line_kind_q;
    have_header_d   = have_header_q;
    error_d         = error_q;
    qpush_o         = 1'b0;
    qword_o.act     = fssu_pkg::ActBase;
    qword_o.code    = match;
    qword_o.close   = 1'b0;
    kind_eff        = line_kind_q;
    cont            = 1'b1;
    if (accept_i) begin
      if (req_type_i) begin
        qpush_o         = 1'b1;
        qword_o.act     = fssu_pkg::ActEof;
        qword_o.close   = !error_q && have_header_q;
        at_line_start_d = 1'b1;
        line_kind_d     = fssu_pkg::LineNone;
        have_header_d   = 1'b0;
        error_d         = 1'b0;
      end else if (!error_q) begin
        if (char_in_i == fssu_pkg::CharNewline) begin
          at_line_start_d = 1'b1;
          line_kind_d     = fssu_pkg::LineNone;
        end else begin
          if (at_line_start_q) begin
            at_line_start_d = 1'b0;
            if (char_in_i == fssu_pkg::CharHeader) begin
              if (have_header_q) begin
                qpush_o     = 1'b1;
                qword_o.act = fssu_pkg::ActClose;
              end
              have_header_d = 1'b1;
              line_kind_d   = fssu_pkg::LineHeader;
              cont          = 1'b0;
            end else if (!have_header_q) begin
              error_d     = 1'b1;
              qpush_o     = 1'b1;
              qword_o.act = fssu_pkg::ActFormat;
              cont        = 1'b0;
            end else begin
              kind_eff    = fssu_pkg::LineSeq;
              line_kind_d = fssu_pkg::LineSeq;
            end
          end
          if (cont && kind_eff == fssu_pkg::LineSeq) begin
            qpush_o = 1'b1;
            if (char_in_i == fssu_pkg::CharSpace) begin
              error_d     = 1'b1;
              qword_o.act = fssu_pkg::ActSpace;
            end else begin
              qword_o.act = fssu_pkg::ActBase;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_line_start_q <= 1'b1;
      line_kind_q     <= fssu_pkg::LineNone;
      have_header_q   <= 1'b0;
      error_q         <= 1'b0;
    end else begin
      at_line_start_q <= at_line_start_d;
      line_kind_q     <= line_kind_d;
      have_header_q   <= have_header_d;
      error_q         <= error_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/fssu_back.sv -----
`default_nettype none

module fssu_back #(
  parameter int NUM_BASES  = 4,
  parameter int COUNT_BITS = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire fssu_pkg::act_t qword_i,
  input  wire logic           qempty_i,
  output logic                qpop_o,
  output logic                rpush_o,
  output fssu_pkg::res_t      rword_o,
  input  wire logic           rfull_i
);

  localparam int StepW = $clog2(NUM_BASES + 2);
  localparam int BaseW = $clog2(NUM_BASES);
  localparam logic [StepW-1:0] StepSummary = StepW'(NUM_BASES + 1);
  localparam logic [COUNT_BITS-1:0] CntOne = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  function automatic logic [31:0] clamp32(input logic [COUNT_BITS-1:0] v);
    logic [63:0] w;
    begin
      w = 64'(v);
      return (|w[63:32]) ? 32'hFFFF_FFFF : w[31:0];
    end
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == CntMax) ? v : v + CntOne;
  endfunction

  logic [COUNT_BITS-1:0] cur_len_q, cur_len_d;
  logic [COUNT_BITS-1:0] rec_cnt_q, rec_cnt_d;
  logic [COUNT_BITS-1:0] short_q, short_d;
  logic [COUNT_BITS-1:0] long_q, long_d;
  logic [COUNT_BITS-1:0] base_q [NUM_BASES];
  logic [COUNT_BITS-1:0] base_d [NUM_BASES];
  logic                  failed_q, failed_d;
  logic [StepW-1:0]      step_q, step_d, eff_step;
  logic [BaseW-1:0]      bidx;
  logic [COUNT_BITS-1:0] base_sel;
  logic                  closing, emit, go, summary;
  logic [COUNT_BITS-1:0] rc_new, sh_new, lo_new;

  assign eff_step = (step_q == '0 && !qword_i.close) ? StepW'(1) : step_q;
  assign bidx     = BaseW'(eff_step - StepW'(1));
  assign summary  = (qword_i.act == fssu_pkg::ActEof) && (eff_step == StepSummary);
  assign closing  = (qword_i.act == fssu_pkg::ActClose) ||
                    ((qword_i.act == fssu_pkg::ActEof) && (eff_step == '0));

  always_comb begin
    base_sel = '0;
    for (int k = 0; k < NUM_BASES; k++) begin
      if (bidx == BaseW'(k)) begin
        base_sel = base_q[k];
      end
    end
  end

  always_comb begin
    rc_new = rec_cnt_q;
    sh_new = short_q;
    lo_new = long_q;
    if (cur_len_q != '0) begin
      rc_new = sat_inc(rec_cnt_q);
      sh_new = (cur_len_q < short_q) ? cur_len_q : short_q;
      lo_new = (cur_len_q > long_q) ? cur_len_q : long_q;
    end
  end

  always_comb begin
    rword_o.kind       = fssu_pkg::KindSummary;
    rword_o.seq_length = '0;
    rword_o.seq_count  = clamp32(rec_cnt_q);
    rword_o.min_length = clamp32(short_q);
    rword_o.max_length = clamp32(long_q);
    rword_o.base_code  = '0;
    rword_o.base_count = '0;
    rword_o.failed     = failed_q;
    rword_o.last       = 1'b0;
    emit               = 1'b1;
    if (closing) begin
      if (cur_len_q != '0) begin
        rword_o.kind       = fssu_pkg::KindRecClosed;
        rword_o.seq_length = clamp32(cur_len_q);
        rword_o.seq_count  = clamp32(rc_new);
        rword_o.min_length = clamp32(sh_new);
        rword_o.max_length = clamp32(lo_new);
      end else begin
        rword_o.kind = fssu_pkg::KindEmpty;
      end
    end else begin
      case (qword_i.act)
        fssu_pkg::ActBase: begin
          rword_o.kind = fssu_pkg::KindUndefBase;
          emit         = (qword_i.code == '0);
        end
        fssu_pkg::ActSpace: begin
          rword_o.kind   = fssu_pkg::KindSpaceErr;
          rword_o.failed = 1'b1;
        end
        fssu_pkg::ActFormat: begin
          rword_o.kind   = fssu_pkg::KindFormatErr;
          rword_o.failed = 1'b1;
        end
        fssu_pkg::ActEof: begin
          if (summary) begin
            rword_o.kind = fssu_pkg::KindSummary;
            rword_o.last = 1'b1;
          end else begin
            rword_o.kind       = fssu_pkg::KindBaseCount;
            rword_o.base_code  = 3'(eff_step);
            rword_o.base_count = clamp32(base_sel);
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  assign go      = !qempty_i && (!emit || !rfull_i);
  assign rpush_o = go && emit;
  assign qpop_o  = go && ((qword_i.act != fssu_pkg::ActEof) || summary);

  always_comb begin
    cur_len_d = cur_len_q;
    rec_cnt_d = rec_cnt_q;
    short_d   = short_q;
    long_d    = long_q;
    failed_d  = failed_q;
    step_d    = step_q;
    for (int k = 0; k < NUM_BASES; k++) begin
      base_d[k] = base_q[k];
    end
    if (go) begin
      if (closing) begin
        rec_cnt_d = rc_new;
        short_d   = sh_new;
        long_d    = lo_new;
        cur_len_d = '0;
      end
      case (qword_i.act)
        fssu_pkg::ActBase: begin
          cur_len_d = sat_inc(cur_len_q);
          for (int k = 0; k < NUM_BASES; k++) begin
            if (qword_i.code == 3'(k + 1)) begin
              base_d[k] = sat_inc(base_q[k]);
            end
          end
        end
        fssu_pkg::ActSpace, fssu_pkg::ActFormat: begin
          failed_d = 1'b1;
        end
        fssu_pkg::ActEof: begin
          if (summary) begin
            step_d    = '0;
            cur_len_d = '0;
            rec_cnt_d = '0;
            short_d   = CntMax;
            long_d    = '0;
            failed_d  = 1'b0;
            for (int k = 0; k < NUM_BASES; k++) begin
              base_d[k] = '0;
            end
          end else begin
            step_d = eff_step + StepW'(1);
          end
        end
        default: step_d = step_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_len_q <= '0;
      rec_cnt_q <= '0;
      short_q   <= CntMax;
      long_q    <= '0;
      failed_q  <= 1'b0;
      step_q    <= '0;
      for (int k = 0; k < NUM_BASES; k++) begin
        base_q[k] <= '0;
      end
    end else begin
      cur_len_q <= cur_len_d;
      rec_cnt_q <= rec_cnt_d;
      short_q   <= short_d;
      long_q    <= long_d;
      failed_q  <= failed_d;
      step_q    <= step_d;
      for (int k = 0; k < NUM_BASES; k++) begin
        base_q[k] <= base_d[k];
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/fasta_stream_statistics_unit.sv -----
`default_nettype none

// FASTA statistics engine. Takes one file byte per cycle while full is low
// (req_type_i = 0) and an end-of-file word (req_type_i = 1). The front end tracks
// line and header state and classifies each byte; only bytes that cause work
// (record close, base count, warnings, fatal errors, end of file) enter a 4-deep
// queue to the back end, which keeps the counters and writes results into a 4-deep
// result queue. Bytes sustain one per cycle while the result side drains. End of
// file makes the back end write a record-close word if a record is open, then
// min(ALPHABET_SIZE,4) base count words and the summary; a stalled result queue backs
// up into the byte queue and then full. Base letters are set over APB (bytes at 0x0,
// 0x4, 0x8, 0xC; reset A C G T) and should only be changed while the block is idle.
// Counters saturate at COUNT_BITS bits and are reported clamped to 32 bits.
module fasta_stream_statistics_unit #(
  parameter int ALPHABET_SIZE = 4,
  parameter int COUNT_BITS    = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic                       req_type_i,
  input  wire logic [7:0]                 char_in_i,
  input  wire logic                       pop,
  output logic                            empty,
  output logic [2:0]                      kind_o,
  output logic [31:0]                     seq_length_o,
  output logic [31:0]                     seq_count_o,
  output logic [31:0]                     min_length_o,
  output logic [31:0]                     max_length_o,
  output logic [2:0]                      base_code_o,
  output logic [31:0]                     base_count_o,
  output logic                            failed_o,
  output logic                            last_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [fssu_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int NumBases = (ALPHABET_SIZE < fssu_pkg::LetterSlots) ?
                            ALPHABET_SIZE : fssu_pkg::LetterSlots;

  logic [fssu_pkg::LetterSlots-1:0][7:0] letter_q;
  logic [1:0]                            reg_idx;
  logic                                  accept;
  logic                                  mid_push, mid_full, mid_empty, mid_pop;
  fssu_pkg::act_t                        mid_wword, mid_rword;
  logic                                  res_push, res_full;
  fssu_pkg::res_t                        res_wword, res_rword;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign prdata  = {24'b0, letter_q[reg_idx]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_q <= fssu_pkg::LetterReset;
    end else if (psel && penable && pwrite && pready) begin
      letter_q[reg_idx] <= pwdata[7:0];
    end
  end

  assign full   = mid_full;
  assign accept = push && !mid_full;

  fssu_front #(
    .NUM_BASES(NumBases)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .req_type_i(req_type_i),
    .char_in_i (char_in_i),
    .letters_i (letter_q),
    .qpush_o   (mid_push),
    .qword_o   (mid_wword)
  );

  fssu_fifo #(
    .WIDTH($bits(fssu_pkg::act_t)),
    .DEPTH(fssu_pkg::MidDepth)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .wdata_i(mid_wword),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .rdata_o(mid_rword),
    .empty_o(mid_empty)
  );

  fssu_back #(
    .NUM_BASES (NumBases),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qword_i (mid_rword),
    .qempty_i(mid_empty),
    .qpop_o  (mid_pop),
    .rpush_o (res_push),
    .rword_o (res_wword),
    .rfull_i (res_full)
  );

  fssu_fifo #(
    .WIDTH($bits(fssu_pkg::res_t)),
    .DEPTH(fssu_pkg::OutDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_wword),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_rword),
    .empty_o(empty)
  );

  assign kind_o       = res_rword.kind;
  assign seq_length_o = res_rword.seq_length;
  assign seq_count_o  = res_rword.seq_count;
  assign min_length_o = res_rword.min_length;
  assign max_length_o = res_rword.max_length;
  assign base_code_o  = res_rword.base_code;
  assign base_count_o = res_rword.base_count;
  assign failed_o     = res_rword.failed;
  assign last_o       = res_rword.last;

endmodule

`default_nettype wire

// ----- design/fssu_checker.sv -----
`default_nettype none

module fssu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [2:0]  kind_o,
  input wire logic [31:0] seq_length_o,
  input wire logic [2:0]  base_code_o,
  input wire logic [31:0] base_count_o,
  input wire logic        failed_o,
  input wire logic        last_o
);

  // a waiting word holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(kind_o) && $stable(seq_length_o)
                       && $stable(base_count_o))
    else $error("result word changed while waiting");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && last_o |-> kind_o == fssu_pkg::KindSummary)
    else $error("last set on a word other than the summary");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o != fssu_pkg::KindBaseCount |-> base_code_o == 3'd0 && base_count_o == '0)
    else $error("base fields set outside a base count word");

  a_fatal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (kind_o == fssu_pkg::KindSpaceErr || kind_o == fssu_pkg::KindFormatErr)
    |-> failed_o)
    else $error("fatal error word without failed");

endmodule

bind fasta_stream_statistics_unit fssu_checker u_fssu_checker (.*);

`default_nettype wire

// ----- dv/fasta_stream_statistics_unit_tb.sv -----
module fasta_stream_statistics_unit_tb;
  import fssu_pkg::*;

  localparam int AlphabetSize = 4;
  localparam int UsedSlots    = (AlphabetSize < LetterSlots) ? AlphabetSize : LetterSlots;
  localparam int PhaseCount   = 8;
  localparam int PhaseWords   = 28;
  localparam int SettleCycles = 20;

  localparam logic       ReqByte      = 1'b0;
  localparam logic       ReqEof       = 1'b1;
  localparam logic [2:0] KindFree     = 3'd7;  // no hand-typed kind for this row
  localparam int         RegLetterOne = 0;

  typedef struct packed {
    logic       req;
    logic [7:0] ch;
    logic [2:0] want;
  } intro_row_t;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                push       = 1'b0;
  logic                req_type_i = ReqByte;
  logic [7:0]          char_in_i  = 8'd0;
  logic                pop        = 1'b0;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [AddrW-1:0]    paddr      = '0;
  logic [31:0]         pwdata     = 32'd0;
  logic                full;
  logic                empty;
  logic [2:0]          kind_o;
  logic [31:0]         seq_length_o;
  logic [31:0]         seq_count_o;
  logic [31:0]         min_length_o;
  logic [31:0]         max_length_o;
  logic [2:0]          base_code_o;
  logic [31:0]         base_count_o;
  logic                failed_o;
  logic                last_o;
  logic [31:0]         prdata;
  logic                pready;

  logic [2:0]          typed_kind = KindFree;

  // statistics mirror
  logic [7:0]          letter_map [LetterSlots];
  logic                line_at_start;
  logic [1:0]          line_state;
  logic                header_open;
  logic [31:0]         record_len;
  logic [31:0]         record_total;
  logic [31:0]         len_shortest;
  logic [31:0]         len_longest;
  logic [31:0]         base_tally [LetterSlots];
  logic                fatal_seen;

  res_t                report_q [$];
  res_t                typed_entry;
  res_t                want_word;
  int                  depth_before;

  int                  gap_pct   = 0;
  int                  stall_pct = 0;
  int                  errors    = 0;
  int                  words_in  = 0;
  int                  words_out = 0;
  int                  stimulus_words = 0;
  int                  files_sent = 0;
  int                  files_broken = 0;

  intro_row_t          intro_rows [0:26];

  fasta_stream_statistics_unit #(
    .ALPHABET_SIZE(AlphabetSize),
    .COUNT_BITS   (32)
  ) dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #(12 * 400000);
    $display("%0t: timeout, %0d result words still outstanding", $time, report_q.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic void post_report(logic [2:0] kind, logic [31:0] len, logic [2:0] code,
                                      logic [31:0] cnt, logic last);
    res_t r;
    r.kind       = kind;
    r.seq_length = len;
    r.seq_count  = record_total;
    r.min_length = len_shortest;
    r.max_length = len_longest;
    r.base_code  = code;
    r.base_count = cnt;
    r.failed     = fatal_seen;
    r.last       = last;
    report_q.insert(report_q.size(), r);
  endfunction

  function automatic void clear_stats();
    line_at_start = 1'b1;
    line_state    = LineNone;
    header_open   = 1'b0;
    record_len    = 32'd0;
    record_total  = 32'd0;
    len_shortest  = '1;
    len_longest   = 32'd0;
    for (int k = 0; k < LetterSlots; k++) base_tally[k] = 32'd0;
    fatal_seen    = 1'b0;
  endfunction

  function automatic void close_entry();
    if (record_len != 32'd0) begin
      record_total = bump(record_total);
      if (record_len < len_shortest) len_shortest = record_len;
      if (record_len > len_longest) len_longest = record_len;
      post_report(KindRecClosed, record_len, 3'd0, 32'd0, 1'b0);
    end else begin
      post_report(KindEmpty, 32'd0, 3'd0, 32'd0, 1'b0);
    end
    record_len  = 32'd0;
    header_open = 1'b0;
  endfunction

  function automatic void tally_word(logic req, logic [7:0] ch);
    if (req == ReqEof) begin
      if (!fatal_seen && header_open) close_entry();
      for (int k = 0; k < UsedSlots; k++) begin
        post_report(KindBaseCount, 32'd0, 3'(k + 1), base_tally[k], 1'b0);
      end
      post_report(KindSummary, 32'd0, 3'd0, 32'd0, 1'b1);
      clear_stats();
      return;
    end
    if (fatal_seen) return;
    if (ch == CharNewline) begin
      line_at_start = 1'b1;
      line_state    = LineNone;
      return;
    end
    if (line_at_start) begin
      line_at_start = 1'b0;
      if (ch == CharHeader) begin
        if (header_open) close_entry();
        header_open = 1'b1;
        line_state  = LineHeader;
        return;
      end
      if (!header_open) begin
        fatal_seen = 1'b1;
        post_report(KindFormatErr, 32'd0, 3'd0, 32'd0, 1'b0);
        return;
      end
      line_state = LineSeq;
    end
    if (line_state != LineSeq) return;
    if (ch == CharSpace) begin
      fatal_seen = 1'b1;
      post_report(KindSpaceErr, 32'd0, 3'd0, 32'd0, 1'b0);
      return;
    end
    record_len = bump(record_len);
    for (int k = 0; k < UsedSlots; k++) begin
      if (letter_map[k] == ch) begin
        base_tally[k] = bump(base_tally[k]);
        return;
      end
    end
    post_report(KindUndefBase, 32'd0, 3'd0, 32'd0, 1'b0);
  endfunction

  task automatic check_field(input string tag, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        depth_before = report_q.size();
        tally_word(req_type_i, char_in_i);
        words_in++;
        if (typed_kind != KindFree && report_q.size() > depth_before) begin
          typed_entry = report_q[depth_before];
          typed_entry.kind = typed_kind;
          report_q[depth_before] = typed_entry;
        end
      end
      if (pop && !empty) begin
        if (report_q.size() == 0) begin
          $display("%0t: unexpected result word, kind %0d", $time, kind_o);
          errors++;
        end else begin
          want_word = report_q.pop_front();
          words_out++;
          check_field("kind", want_word.kind, kind_o);
          check_field("seq_length", want_word.seq_length, seq_length_o);
          check_field("seq_count", want_word.seq_count, seq_count_o);
          check_field("min_length", want_word.min_length, min_length_o);
          check_field("max_length", want_word.max_length, max_length_o);
          check_field("base_code", want_word.base_code, base_code_o);
          check_field("base_count", want_word.base_count, base_count_o);
          check_field("failed", want_word.failed, failed_o);
          check_field("last", want_word.last, last_o);
        end
      end
    end
  end

  task automatic push_word(input logic req, input logic [7:0] ch, input logic [2:0] want);
    while ($urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push       <= 1'b1;
    req_type_i <= req;
    char_in_i  <= ch;
    typed_kind <= want;
    do @(posedge clk_i); while (full);
  endtask

  task automatic settle();
    push <= 1'b0;
    do @(posedge clk_i); while (report_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write one letter, then read it back
  task automatic program_letter(input int idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * (RegLetterOne + idx));
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    letter_map[idx] = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {24'd0, value}) begin
      $display("%0t: letter %0d readback, expected %0d, actual %0d", $time, idx, value, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic stream_file();
    logic [7:0] body [$];
    logic [7:0] b;
    int         records;
    int         lines;
    int         len;
    int         cut;
    bit         broken;
    records = $urandom_range(1, 4);
    for (int r = 0; r < records; r++) begin
      body.insert(body.size(), CharHeader);
      len = $urandom_range(0, 4);
      for (int i = 0; i < len; i++) begin
        do b = 8'($urandom_range(0, 255)); while (b == CharNewline);
        body.insert(body.size(), b);
      end
      body.insert(body.size(), CharNewline);
      lines = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      for (int l = 0; l < lines; l++) begin
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < 85) begin
            b = letter_map[$urandom_range(0, UsedSlots - 1)];
          end else begin
            do b = 8'($urandom_range(0, 255)); while (b == CharNewline || b == CharSpace);
          end
          body.insert(body.size(), b);
        end
        if (r != records - 1 || l != lines - 1 || $urandom_range(0, 1) == 0) begin
          body.insert(body.size(), CharNewline);
        end
      end
    end
    broken = ($urandom_range(0, 99) < 12);
    cut = body.size();
    if (broken) begin
      files_broken++;
      if ($urandom_range(0, 1) == 0) begin
        cut = 0;
        body.push_front(8'h4E);
      end else begin
        cut = $urandom_range(0, body.size());
        body.insert(cut, CharSpace);
      end
    end
    for (int i = 0; i < body.size(); i++) begin
      push_word(ReqByte, body[i], KindFree);
      stimulus_words++;
    end
    push_word(ReqEof, 8'($urandom_range(0, 255)), KindFree);
    stimulus_words++;
    files_sent++;
  endtask

  initial begin
    logic [7:0] plan [LetterSlots];
    for (int k = 0; k < LetterSlots; k++) letter_map[k] = LetterReset[k];
    clear_stats();

    intro_rows = '{
      {ReqByte, "A",         KindFormatErr},  // sequence before any header
      {ReqEof,  8'h00,       KindBaseCount},
      {ReqByte, CharHeader,  KindFree},
      {ReqByte, "x",         KindFree},
      {ReqByte, CharNewline, KindFree},
      {ReqByte, "A",         KindFree},
      {ReqByte, "C",         KindFree},
      {ReqByte, "G",         KindFree},
      {ReqByte, "T",         KindFree},
      {ReqByte, "N",         KindUndefBase},
      {ReqByte, 8'h00,       KindUndefBase},
      {ReqByte, 8'h0D,       KindUndefBase},  // carriage return
      {ReqByte, CharNewline, KindFree},
      {ReqByte, CharHeader,  KindRecClosed},
      {ReqByte, CharNewline, KindFree},
      {ReqByte, CharHeader,  KindEmpty},      // header without sequence
      {ReqByte, CharNewline, KindFree},
      {ReqByte, CharNewline, KindFree},       // blank line
      {ReqByte, "G",         KindFree},
      {ReqByte, 8'hFF,       KindUndefBase},
      {ReqByte, CharSpace,   KindSpaceErr},
      {ReqByte, 8'hFF,       KindFree},       // dropped after fatal error
      {ReqEof,  8'hFF,       KindBaseCount},
      {ReqByte, CharHeader,  KindFree},
      {ReqByte, CharNewline, KindFree},
      {ReqByte, "T",         KindFree},
      {ReqEof,  8'h00,       KindRecClosed}   // unterminated last line
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        1: plan = '{8'h00, 8'hFF, "A", "A"};
        2: plan = '{"a", "c", "g", "t"};
        3: plan = '{8'hFF, 8'h00, CharHeader, CharSpace};
        7: plan = '{LetterReset[0], LetterReset[1], LetterReset[2], LetterReset[3]};
        default: begin
          for (int k = 0; k < LetterSlots; k++) plan[k] = 8'($urandom_range(0, 255));
        end
      endcase
      if (phase != 0) begin
        for (int k = 0; k < LetterSlots; k++) program_letter(k, plan[k]);
      end
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 65; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 65; end
        default: begin gap_pct = 6; stall_pct = 6; end
      endcase
      if (phase == 0) begin
        foreach (intro_rows[i]) push_word(intro_rows[i].req, intro_rows[i].ch, intro_rows[i].want);
      end
      stimulus_words = 0;
      while (stimulus_words < PhaseWords) stream_file();
      settle();
    end

    $display("Checked %0d result words against %0d input words over %0d letter settings.",
             words_out, words_in, PhaseCount);
    $display("Random files: %0d, of which %0d malformed.", files_sent, files_broken);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
